>>> rtl/jbt_pkg.sv
// Shared types, character codes and keyword tables for the JSON byte tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package jbt_pkg;

    // Default width of the offset and line counters
    localparam int OFFSET_BITS_DEF = 32;

    // Result slots per source byte: mode token, rescan token, flush token, end token
    localparam int SLOTS = 4;

    // Token kinds
    localparam logic [3:0] TK_ERROR  = 4'd0;
    localparam logic [3:0] TK_LBRACE = 4'd1;
    localparam logic [3:0] TK_RBRACE = 4'd2;
    localparam logic [3:0] TK_LBRACK = 4'd3;
    localparam logic [3:0] TK_RBRACK = 4'd4;
    localparam logic [3:0] TK_COLON  = 4'd5;
    localparam logic [3:0] TK_COMMA  = 4'd6;
    localparam logic [3:0] TK_STRING = 4'd7;
    localparam logic [3:0] TK_TRUE   = 4'd8;
    localparam logic [3:0] TK_FALSE  = 4'd9;
    localparam logic [3:0] TK_NULL   = 4'd10;
    localparam logic [3:0] TK_NUMBER = 4'd11;
    localparam logic [3:0] TK_END    = 4'd12;

    // Error kinds
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_KEYWORD    = 2'd2;

    // Keyword selectors
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // One result item
    typedef struct packed {
        logic [1:0]  err;
        logic [31:0] col;
        logic [31:0] line;
        logic [31:0] len;
        logic [31:0] start;
        logic [3:0]  kind;
    } res_t;

    // Number of bytes after the first letter of a keyword
    function automatic logic [2:0] kw_len(input logic [1:0] sel);
        logic [2:0] n;
        case (sel)
            KW_FALSE: n = 3'd4;
            default:  n = 3'd3;
        endcase
        return n;
    endfunction

    // Token kind of a keyword
    function automatic logic [3:0] kw_kind(input logic [1:0] sel);
        logic [3:0] k;
        case (sel)
            KW_FALSE: k = TK_FALSE;
            KW_NULL:  k = TK_NULL;
            default:  k = TK_TRUE;
        endcase
        return k;
    endfunction

    // Expected byte at a position of a keyword tail
    function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (sel)
            KW_FALSE:
            begin
                case (pos)
                    3'd0:    c = CH_A;
                    3'd1:    c = CH_L;
                    3'd2:    c = CH_S;
                    3'd3:    c = CH_E_LO;
                    default: c = 8'h00;
                endcase
            end
            KW_NULL:
            begin
                case (pos)
                    3'd0:    c = CH_U;
                    3'd1:    c = CH_L;
                    3'd2:    c = CH_L;
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0:    c = CH_R;
                    3'd1:    c = CH_U;
                    3'd2:    c = CH_E_LO;
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/jbt_scan.sv
// Scanner state and per-byte token logic of the JSON byte tokenizer.
`timescale 1ns / 1ps
`default_nettype none

module jbt_scan #(
    parameter int OFFSET_BITS = jbt_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   step,
    input  wire logic [7:0]                             byte_in,
    input  wire logic                                   eos_in,
    output jbt_pkg::res_t [jbt_pkg::SLOTS-1:0]          cand,
    output logic          [jbt_pkg::SLOTS-1:0]          cand_vld
);

    typedef logic [OFFSET_BITS-1:0] off_t;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_STRING  = 4'd1,
        M_KEYWORD = 4'd2,
        M_MINUS   = 4'd3,
        M_ZERO    = 4'd4,
        M_INT     = 4'd5,
        M_FRAC    = 4'd6,
        M_EXP     = 4'd7,
        M_EXPD    = 4'd8
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic [1:0] ksel_reg, ksel_next;
    logic [2:0] kprog_reg, kprog_next;
    off_t       pstart_reg, pstart_next;
    off_t       off_reg, off_next;
    off_t       lcnt_reg, lcnt_next;
    off_t       lbeg_reg, lbeg_next;

    off_t       nxt;
    logic       is_digit;

    // Saturate an offset to the 32-bit result fields
    function automatic logic [31:0] sat32(input off_t v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    // Increment, holding at all ones
    function automatic off_t inc_sat(input off_t v);
        return (v == '1) ? v : v + OFFSET_BITS'(1);
    endfunction

    // Distance from one offset to another, zero if negative
    function automatic off_t span(input off_t from, input off_t to);
        return (to >= from) ? to - from : '0;
    endfunction

    // Build one result item
    function automatic jbt_pkg::res_t mk_res(input logic [3:0] kind, input off_t start,
                                             input off_t len, input logic [1:0] err,
                                             input off_t lcnt, input off_t lbeg);
        jbt_pkg::res_t r;
        r.kind  = kind;
        r.start = sat32(start);
        r.len   = sat32(len);
        r.line  = sat32(lcnt);
        r.col   = sat32(span(lbeg, start));
        r.err   = err;
        return r;
    endfunction

    assign nxt      = inc_sat(off_reg);
    assign is_digit = byte_in inside {[jbt_pkg::CH_ZERO:jbt_pkg::CH_NINE]};

    // Scan one byte: pending token, rescan from idle, flush on the final byte
    always_comb
    begin
        logic       rescan;
        logic [2:0] kl;
        logic       a_vld, b_vld, c_vld;
        logic [3:0] a_kind, b_kind, c_kind;
        logic [1:0] a_err, b_err, c_err;
        off_t       a_len, c_len, b_start;

        mode_next   = mode_reg;
        esc_next    = esc_reg;
        ksel_next   = ksel_reg;
        kprog_next  = kprog_reg;
        pstart_next = pstart_reg;
        lcnt_next   = lcnt_reg;
        lbeg_next   = lbeg_reg;
        off_next    = nxt;
        rescan      = 1'b0;
        kl          = jbt_pkg::kw_len(ksel_reg);
        a_vld       = 1'b0;
        a_kind      = jbt_pkg::TK_NUMBER;
        a_err       = jbt_pkg::ERR_NONE;
        a_len       = span(pstart_reg, off_reg);
        b_vld       = 1'b0;
        b_kind      = jbt_pkg::TK_ERROR;
        b_err       = jbt_pkg::ERR_NONE;
        b_start     = off_reg;
        c_vld       = 1'b0;
        c_kind      = jbt_pkg::TK_NUMBER;
        c_err       = jbt_pkg::ERR_NONE;
        c_len       = '0;

        // Advance the pending token
        case (mode_reg)
            M_STRING:
            begin
                if (esc_reg && byte_in == jbt_pkg::CH_QUOTE)
                begin
                    esc_next = 1'b0;
                end
                else if (byte_in == jbt_pkg::CH_BSLASH)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    esc_next = 1'b0;
                    if (byte_in == jbt_pkg::CH_QUOTE)
                    begin
                        a_vld     = 1'b1;
                        a_kind    = jbt_pkg::TK_STRING;
                        mode_next = M_IDLE;
                    end
                end
            end
            M_KEYWORD:
            begin
                if (kprog_reg < kl && byte_in == jbt_pkg::kw_char(ksel_reg, kprog_reg))
                begin
                    if (kprog_reg + 3'd1 >= kl)
                    begin
                        a_vld      = 1'b1;
                        a_kind     = jbt_pkg::kw_kind(ksel_reg);
                        a_len      = OFFSET_BITS'(kl) + OFFSET_BITS'(1);
                        mode_next  = M_IDLE;
                        kprog_next = 3'd0;
                    end
                    else
                    begin
                        kprog_next = kprog_reg + 3'd1;
                    end
                end
                else
                begin
                    a_vld      = 1'b1;
                    a_kind     = jbt_pkg::TK_ERROR;
                    a_err      = jbt_pkg::ERR_KEYWORD;
                    kprog_next = 3'd0;
                    rescan     = 1'b1;
                end
            end
            M_MINUS:
            begin
                if (byte_in == jbt_pkg::CH_ZERO)
                begin
                    mode_next = M_ZERO;
                end
                else if (is_digit)
                begin
                    mode_next = M_INT;
                end
                else
                begin
                    a_vld  = 1'b1;
                    a_kind = jbt_pkg::TK_ERROR;
                    a_err  = jbt_pkg::ERR_UNEXPECTED;
                    a_len  = OFFSET_BITS'(1);
                    rescan = 1'b1;
                end
            end
            M_ZERO, M_INT, M_FRAC:
            begin
                if (is_digit && mode_reg != M_ZERO)
                begin
                    mode_next = mode_reg;
                end
                else if (byte_in == jbt_pkg::CH_DOT && mode_reg != M_FRAC)
                begin
                    mode_next = M_FRAC;
                end
                else if (byte_in == jbt_pkg::CH_E_LO || byte_in == jbt_pkg::CH_E_UP)
                begin
                    mode_next = M_EXP;
                end
                else
                begin
                    a_vld  = 1'b1;
                    rescan = 1'b1;
                end
            end
            M_EXP:
            begin
                if (byte_in == jbt_pkg::CH_PLUS || byte_in == jbt_pkg::CH_MINUS || is_digit)
                begin
                    mode_next = M_EXPD;
                end
                else
                begin
                    a_vld  = 1'b1;
                    rescan = 1'b1;
                end
            end
            M_EXPD:
            begin
                if (!is_digit)
                begin
                    a_vld  = 1'b1;
                    rescan = 1'b1;
                end
            end
            default:
            begin
                rescan = 1'b1;
            end
        endcase

        // Rescan the byte as the start of a new token
        if (rescan)
        begin
            mode_next = M_IDLE;
            case (byte_in) inside
                jbt_pkg::CH_SPACE, jbt_pkg::CH_TAB, jbt_pkg::CH_CR:
                begin
                    mode_next = M_IDLE;
                end
                jbt_pkg::CH_LF:
                begin
                    lcnt_next = inc_sat(lcnt_reg);
                    lbeg_next = nxt;
                end
                jbt_pkg::CH_LBRACE:
                begin
                    b_vld  = 1'b1;
                    b_kind = jbt_pkg::TK_LBRACE;
                end
                jbt_pkg::CH_RBRACE:
                begin
                    b_vld  = 1'b1;
                    b_kind = jbt_pkg::TK_RBRACE;
                end
                jbt_pkg::CH_LBRACK:
                begin
                    b_vld  = 1'b1;
                    b_kind = jbt_pkg::TK_LBRACK;
                end
                jbt_pkg::CH_RBRACK:
                begin
                    b_vld  = 1'b1;
                    b_kind = jbt_pkg::TK_RBRACK;
                end
                jbt_pkg::CH_COLON:
                begin
                    b_vld  = 1'b1;
                    b_kind = jbt_pkg::TK_COLON;
                end
                jbt_pkg::CH_COMMA:
                begin
                    b_vld  = 1'b1;
                    b_kind = jbt_pkg::TK_COMMA;
                end
                jbt_pkg::CH_QUOTE:
                begin
                    mode_next   = M_STRING;
                    esc_next    = 1'b0;
                    pstart_next = nxt;
                end
                jbt_pkg::CH_T, jbt_pkg::CH_F, jbt_pkg::CH_N:
                begin
                    mode_next   = M_KEYWORD;
                    kprog_next  = 3'd0;
                    pstart_next = off_reg;
                    if (byte_in == jbt_pkg::CH_T)
                    begin
                        ksel_next = jbt_pkg::KW_TRUE;
                    end
                    else if (byte_in == jbt_pkg::CH_F)
                    begin
                        ksel_next = jbt_pkg::KW_FALSE;
                    end
                    else
                    begin
                        ksel_next = jbt_pkg::KW_NULL;
                    end
                end
                jbt_pkg::CH_MINUS:
                begin
                    mode_next   = M_MINUS;
                    pstart_next = off_reg;
                end
                jbt_pkg::CH_ZERO:
                begin
                    mode_next   = M_ZERO;
                    pstart_next = off_reg;
                end
                [jbt_pkg::CH_ONE:jbt_pkg::CH_NINE]:
                begin
                    mode_next   = M_INT;
                    pstart_next = off_reg;
                end
                default:
                begin
                    b_vld  = 1'b1;
                    b_kind = jbt_pkg::TK_ERROR;
                    b_err  = jbt_pkg::ERR_UNEXPECTED;
                end
            endcase
        end

        // Flush what is still pending on the final byte
        if (eos_in)
        begin
            case (mode_next)
                M_STRING:
                begin
                    c_vld  = 1'b1;
                    c_kind = jbt_pkg::TK_STRING;
                    c_len  = span(pstart_next, nxt);
                end
                M_KEYWORD:
                begin
                    c_vld  = 1'b1;
                    c_kind = jbt_pkg::TK_ERROR;
                    c_err  = jbt_pkg::ERR_KEYWORD;
                    c_len  = span(pstart_next, nxt);
                end
                M_MINUS:
                begin
                    c_vld  = 1'b1;
                    c_kind = jbt_pkg::TK_ERROR;
                    c_err  = jbt_pkg::ERR_UNEXPECTED;
                    c_len  = OFFSET_BITS'(1);
                end
                M_ZERO, M_INT, M_FRAC, M_EXP, M_EXPD:
                begin
                    c_vld  = 1'b1;
                    c_len  = span(pstart_next, nxt);
                end
                default:
                begin
                    c_vld = 1'b0;
                end
            endcase
        end

        // Result candidates in emission order
        cand[0]  = mk_res(a_kind, pstart_reg, a_len, a_err, lcnt_reg, lbeg_reg);
        cand[1]  = mk_res(b_kind, b_start, OFFSET_BITS'(1), b_err, lcnt_reg, lbeg_reg);
        cand[2]  = mk_res(c_kind, pstart_next, c_len, c_err, lcnt_next, lbeg_next);
        cand[3]  = mk_res(jbt_pkg::TK_END, nxt, '0, jbt_pkg::ERR_NONE, lcnt_next, lbeg_next);
        cand_vld = {eos_in, c_vld, b_vld, a_vld};

        // Return to reset after the final byte
        if (eos_in)
        begin
            mode_next   = M_IDLE;
            esc_next    = 1'b0;
            ksel_next   = jbt_pkg::KW_TRUE;
            kprog_next  = 3'd0;
            pstart_next = '0;
            off_next    = '0;
            lcnt_next   = '0;
            lbeg_next   = '0;
        end
    end

    // Hold scanner state, advance once per scanned byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            esc_reg    <= 1'b0;
            ksel_reg   <= jbt_pkg::KW_TRUE;
            kprog_reg  <= 3'd0;
            pstart_reg <= '0;
            off_reg    <= '0;
            lcnt_reg   <= '0;
            lbeg_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            esc_reg    <= esc_next;
            ksel_reg   <= ksel_next;
            kprog_reg  <= kprog_next;
            pstart_reg <= pstart_next;
            off_reg    <= off_next;
            lcnt_reg   <= lcnt_next;
            lbeg_reg   <= lbeg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/jbt_obuf.sv
// Result buffer: holds the tokens of one byte and drains them in order.
`timescale 1ns / 1ps
`default_nettype none

module jbt_obuf (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  load,
    input  wire jbt_pkg::res_t [jbt_pkg::SLOTS-1:0]    cand,
    input  wire logic          [jbt_pkg::SLOTS-1:0]    cand_vld,
    output logic                                       free,
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output jbt_pkg::res_t                              res,
    output logic                                       res_last
);

    jbt_pkg::res_t [jbt_pkg::SLOTS-1:0] slot_reg;
    logic [jbt_pkg::SLOTS-1:0]          mask_reg, mask_next;
    logic [$clog2(jbt_pkg::SLOTS)-1:0]  sel;

    // Pick the oldest pending slot
    always_comb
    begin
        sel = '0;
        for (int i = jbt_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = ($clog2(jbt_pkg::SLOTS))'(i);
            end
        end
    end

    assign res_valid = |mask_reg;
    assign res_last  = res_valid && ((mask_reg & (mask_reg - 1'b1)) == '0);
    assign res       = slot_reg[sel];
    assign free      = !res_valid || (res_last && res_ready);

    // Load a new set of results or drop the one just taken
    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = cand_vld;
        end
        else if (res_valid && res_ready)
        begin
            mask_next = mask_reg & (mask_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= cand;
        end
    end

endmodule

`default_nettype wire

>>> rtl/json_byte_tokenizer.sv
// Top level of the JSON byte tokenizer: input register, scanner, result buffer.
`timescale 1ns / 1ps
`default_nettype none

// JSON byte tokenizer. Source bytes enter on the s_ stream, one per transaction,
// with s_tlast on the final byte; tokens leave on the m_ stream with m_tlast on
// the last token that a byte causes. A byte is registered and scanned, and
// its tokens (none to three) land in a four-slot result buffer. The block
// takes one byte per cycle while each byte yields at most one token and the
// output is ready; the tokens of a byte leave one by one on the single output
// port, and the next byte is scanned in the cycle its last token is taken.
// Offsets and line counts are OFFSET_BITS wide and saturate; results are
// clipped to 32 bits. After the final byte all counters return to zero.
module json_byte_tokenizer #(
    parameter int OFFSET_BITS = jbt_pkg::OFFSET_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] byte_value
    input  wire logic         s_tlast,   // end_of_source
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // [31:0] token_start, [63:32] token_length,
                                         // [95:64] line_number, [127:96] column
    output logic [7:0]        m_tuser,   // [3:0] token_kind, [5:4] error_kind, [7:6] zero
    output logic              m_tlast    // last_result
);

    logic                               in_vld_reg;
    logic [7:0]                         in_byte_reg;
    logic                               in_eos_reg;
    logic                               free;
    logic                               step;
    jbt_pkg::res_t [jbt_pkg::SLOTS-1:0] cand;
    logic          [jbt_pkg::SLOTS-1:0] cand_vld;
    jbt_pkg::res_t                      res;

    // Scan the held byte once the buffer can take its tokens
    assign step     = in_vld_reg && free;
    assign s_tready = !in_vld_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (step)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // Capture the transaction payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    jbt_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .byte_in  (in_byte_reg),
        .eos_in   (in_eos_reg),
        .cand     (cand),
        .cand_vld (cand_vld)
    );

    jbt_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .cand      (cand),
        .cand_vld  (cand_vld),
        .free      (free),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res),
        .res_last  (m_tlast)
    );

    // Pack the result fields
    assign m_tdata = {res.col, res.line, res.len, res.start};
    assign m_tuser = {2'b00, res.err, res.kind};

`ifndef SYNTHESIS
    // A held byte waits while the buffer still has more than its last token or that token is not taken
    ap_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !free |=> in_vld_reg)
        else $error("input byte dropped while result buffer busy");

    // The final byte always produces an end token
    ap_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_eos_reg |=> m_tvalid)
        else $error("no result after final byte");

    // Taking the last token with nothing new scanned empties the buffer
    ap_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tready && !step |=> !m_tvalid)
        else $error("result buffer not empty after last token");

    // A byte is scanned only when the output side can absorb its tokens
    ap_scan_free: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> (!m_tvalid || (m_tlast && m_tready)))
        else $error("byte scanned over pending tokens");
`endif

endmodule

`default_nettype wire
